FILE: rtl/core/gradient_veil_compositor_macros.svh
// assertion macros for the gradient veil compositor
// expects clk and rst_n in the scope of the including module
`ifndef GRADIENT_VEIL_COMPOSITOR_MACROS_SVH
`define GRADIENT_VEIL_COMPOSITOR_MACROS_SVH

// property holds in the same cycle
`define GVC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gvc check failed");

// property holds in the next cycle
`define GVC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gvc check failed");

`endif

FILE: rtl/core/gvc_pkg.sv
// shared types, constants and the blend function of the gradient veil compositor
// no dependencies
`default_nettype none

package gvc_pkg;

    localparam int FRAC_BITS  = 4;
    localparam int MAX_LAYERS = 3;
    localparam int DIV_STEPS  = 8;
    localparam int LANES      = 6;
    localparam int NUM_STAGES = DIV_STEPS + 2 + MAX_LAYERS;
    localparam int LAST_STAGE = NUM_STAGES - 1;

    localparam logic [2:0] REG_SCREEN_HEIGHT   = 3'd0;
    localparam logic [2:0] REG_GRADIENT_TOP    = 3'd1;
    localparam logic [2:0] REG_GRADIENT_BOTTOM = 3'd2;
    localparam logic [2:0] REG_TINT_FIRST      = 3'd3;
    localparam logic [2:0] REG_TINT_SECOND     = 3'd4;
    localparam logic [2:0] REG_TINT_THIRD      = 3'd5;
    localparam logic [2:0] REG_CREST_ALPHAS    = 3'd6;

    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd720;
    localparam logic [23:0] RST_TINT_FIRST    = 24'h4A52A8;
    localparam logic [23:0] RST_TINT_SECOND   = 24'h6C5BD4;
    localparam logic [23:0] RST_TINT_THIRD    = 24'h3A4290;
    localparam logic [23:0] RST_CREST_ALPHAS  = 24'h482A38;

    localparam logic [7:0] FULL_ALPHA = 8'd255;

    typedef enum logic [1:0] {
        GM_TOP,
        GM_BOT,
        GM_MIX
    } grad_mode_t;

    typedef struct packed {
        logic [23:0] rem;
        logic [15:0] dvs;
        logic [7:0]  quo;
    } div_lane_t;

    typedef struct packed {
        grad_mode_t [2:0] mode;
        logic [2:0]       neg;
    } side_t;

    // (src*a + dst*(255-a)) / 255, the divide done by reciprocal fold
    function automatic logic [7:0] blend8(logic [7:0] src, logic [7:0] dst, logic [7:0] a);
        logic [15:0] x;
        logic [16:0] s;
        x = {8'b0, src} * {8'b0, a} + {8'b0, dst} * {8'b0, FULL_ALPHA - a};
        s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gradient_veil_compositor.sv
// gradient veil compositor top level: gradient, three ribbon veils, apb registers
// depends on gvc_pkg and gradient_veil_compositor_macros.svh
`default_nettype none
`include "gradient_veil_compositor_macros.svh"

// channel     direction  contents
// s_axis      in         row, three crest rows, layer count (one transaction per pixel)
// m_axis      out        red, green, blue (one transaction per input transaction)
// apb         in/out     seven configuration registers at byte address 4*index
//
// one transaction per clock sustained while the output is not stalled; the output is registered
// the pipeline holds the 8-step restoring divide (one quotient bit per stage)
// rst_n clears valid bits and loads the register reset values
// a stalled output freezes the whole pipeline; s_axis_tready drops until it moves
// registers may only be written while no transaction is in flight

module gradient_veil_compositor
    import gvc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // [14:0] pixel_row, [29:15] crest_first, [44:30] crest_second,
    // [59:45] crest_third, [61:60] layer_count, [63:62] zero
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [11:0] screen_height_reg;
    logic [23:0] gradient_top_reg;
    logic [23:0] gradient_bottom_reg;
    logic [23:0] tint_reg [0:2];
    logic [23:0] crest_alphas_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg   <= RST_SCREEN_HEIGHT;
            gradient_top_reg    <= '0;
            gradient_bottom_reg <= '0;
            tint_reg[0]         <= RST_TINT_FIRST;
            tint_reg[1]         <= RST_TINT_SECOND;
            tint_reg[2]         <= RST_TINT_THIRD;
            crest_alphas_reg    <= RST_CREST_ALPHAS;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SCREEN_HEIGHT:   screen_height_reg   <= pwdata[11:0];
                REG_GRADIENT_TOP:    gradient_top_reg    <= pwdata[23:0];
                REG_GRADIENT_BOTTOM: gradient_bottom_reg <= pwdata[23:0];
                REG_TINT_FIRST:      tint_reg[0]         <= pwdata[23:0];
                REG_TINT_SECOND:     tint_reg[1]         <= pwdata[23:0];
                REG_TINT_THIRD:      tint_reg[2]         <= pwdata[23:0];
                REG_CREST_ALPHAS:    crest_alphas_reg    <= pwdata[23:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SCREEN_HEIGHT:   prdata = {20'b0, screen_height_reg};
            REG_GRADIENT_TOP:    prdata = {8'b0, gradient_top_reg};
            REG_GRADIENT_BOTTOM: prdata = {8'b0, gradient_bottom_reg};
            REG_TINT_FIRST:      prdata = {8'b0, tint_reg[0]};
            REG_TINT_SECOND:     prdata = {8'b0, tint_reg[1]};
            REG_TINT_THIRD:      prdata = {8'b0, tint_reg[2]};
            REG_CREST_ALPHAS:    prdata = {8'b0, crest_alphas_reg};
            default:             prdata = '0;
        endcase
    end

    // pipeline control: global advance, output register is the last stage
    logic [LAST_STAGE:0] valid_reg;
    logic                adv;

    assign adv           = m_axis_tready || !valid_reg[LAST_STAGE];
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[LAST_STAGE-1:0], s_axis_tvalid};
    end

    // stage 0: field unpack, mode decode, dividend and divisor products
    logic [14:0] row;
    logic [14:0] crest [0:2];
    logic [1:0]  layer_count;
    logic [15:0] hf;
    logic [15:0] span;
    logic [15:0] row_w;

    div_lane_t lane_next [0:LANES-1];
    side_t     side_next;

    assign row         = s_axis_tdata[14:0];
    assign crest[0]    = s_axis_tdata[29:15];
    assign crest[1]    = s_axis_tdata[44:30];
    assign crest[2]    = s_axis_tdata[59:45];
    assign layer_count = s_axis_tdata[61:60];
    assign hf          = {screen_height_reg, 4'b0};
    assign span        = {screen_height_reg - 12'd1, 4'b0};
    assign row_w       = {1'b0, row};

    always_comb
    begin
        logic [7:0]  top;
        logic [7:0]  bot;
        logic [7:0]  mag;
        logic [7:0]  peak;
        grad_mode_t  gm;
        logic        act;
        for (int l = 0; l < 3; l++)
        begin
            top = gradient_top_reg[16 - 8 * l +: 8];
            bot = gradient_bottom_reg[16 - 8 * l +: 8];
            if (screen_height_reg <= 12'd1 || row == 15'd0)
                gm = GM_TOP;
            else if (row_w >= span)
                gm = GM_BOT;
            else
                gm = GM_MIX;
            side_next.mode[l] = gm;
            side_next.neg[l]  = bot < top;
            mag = (bot < top) ? top - bot : bot - top;
            lane_next[l].quo = '0;
            if (gm == GM_MIX)
            begin
                lane_next[l].rem = {16'b0, mag} * {9'b0, row};
                lane_next[l].dvs = span;
            end
            else
            begin
                lane_next[l].rem = '0;
                lane_next[l].dvs = 16'd1;
            end
        end
        // ribbon alpha: inactive or fully faded ribbons divide zero by one
        for (int j = 0; j < MAX_LAYERS; j++)
        begin
            peak = crest_alphas_reg[8 * j +: 8];
            act  = ({30'b0, layer_count} > j) && (crest[j] <= row) && (row_w < hf);
            lane_next[3 + j].quo = '0;
            if (act)
            begin
                lane_next[3 + j].rem = {16'b0, peak} * {8'b0, hf - row_w};
                lane_next[3 + j].dvs = hf - {1'b0, crest[j]};
            end
            else
            begin
                lane_next[3 + j].rem = '0;
                lane_next[3 + j].dvs = 16'd1;
            end
        end
    end

    // stages 1..8: restoring divide, one quotient bit per stage, msb first
    div_lane_t dv_reg   [0:DIV_STEPS][0:LANES-1];
    side_t     side_reg [0:DIV_STEPS];
    div_lane_t dv_next  [1:DIV_STEPS][0:LANES-1];

    always_comb
    begin
        logic [23:0] trial;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial = {8'b0, dv_reg[s][l].dvs} << (DIV_STEPS - 1 - s);
                dv_next[s + 1][l].dvs = dv_reg[s][l].dvs;
                if (dv_reg[s][l].rem >= trial)
                begin
                    dv_next[s + 1][l].rem = dv_reg[s][l].rem - trial;
                    dv_next[s + 1][l].quo = {dv_reg[s][l].quo[6:0], 1'b1};
                end
                else
                begin
                    dv_next[s + 1][l].rem = dv_reg[s][l].rem;
                    dv_next[s + 1][l].quo = {dv_reg[s][l].quo[6:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0]   <= lane_next;
            side_reg[0] <= side_next;
            for (int s = 1; s <= DIV_STEPS; s++)
            begin
                dv_reg[s]   <= dv_next[s];
                side_reg[s] <= side_reg[s - 1];
            end
        end
    end

    // stage 9: gradient colour from quotient; stages 10..12: one ribbon blend each
    logic [23:0]     col_reg   [0:MAX_LAYERS];
    logic [2:0][7:0] alpha_reg [0:MAX_LAYERS-1];
    logic [23:0]     grad_next;
    logic [23:0]     blend_next [0:MAX_LAYERS-1];

    always_comb
    begin
        logic [7:0] top;
        logic [7:0] bot;
        logic [7:0] q;
        for (int l = 0; l < 3; l++)
        begin
            top = gradient_top_reg[16 - 8 * l +: 8];
            bot = gradient_bottom_reg[16 - 8 * l +: 8];
            q   = dv_reg[DIV_STEPS][l].quo;
            case (side_reg[DIV_STEPS].mode[l])
                GM_TOP:  grad_next[16 - 8 * l +: 8] = top;
                GM_BOT:  grad_next[16 - 8 * l +: 8] = bot;
                GM_MIX:  grad_next[16 - 8 * l +: 8] =
                             side_reg[DIV_STEPS].neg[l] ? top - q : top + q;
                default: grad_next[16 - 8 * l +: 8] = top;
            endcase
        end
        for (int j = 0; j < MAX_LAYERS; j++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                blend_next[j][16 - 8 * l +: 8] = blend8(tint_reg[j][16 - 8 * l +: 8],
                    col_reg[j][16 - 8 * l +: 8], alpha_reg[j][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_reg[0] <= grad_next;
            for (int j = 0; j < MAX_LAYERS; j++)
                alpha_reg[0][j] <= dv_reg[DIV_STEPS][3 + j].quo;
            for (int j = 0; j < MAX_LAYERS; j++)
                col_reg[j + 1] <= blend_next[j];
            for (int j = 1; j < MAX_LAYERS; j++)
                alpha_reg[j] <= alpha_reg[j - 1];
        end
    end

    assign m_axis_tvalid = valid_reg[LAST_STAGE];
    assign m_axis_tdata  = {col_reg[MAX_LAYERS][7:0], col_reg[MAX_LAYERS][15:8],
                            col_reg[MAX_LAYERS][23:16]};

    // a waiting result holds the pipeline
    `GVC_ASSERT_NOW(a_stall_freezes, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    // an accepted transaction enters the first stage
    `GVC_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, valid_reg[0])
    // first ribbon alpha never exceeds its crest alpha
    `GVC_ASSERT_NOW(a_alpha_bound, valid_reg[DIV_STEPS],
        dv_reg[DIV_STEPS][3].quo <= crest_alphas_reg[7:0])
    // the first colour lane leaves a zero quotient outside the gradient interior
    `GVC_ASSERT_NOW(a_flat_zero_quo,
        valid_reg[DIV_STEPS] && side_reg[DIV_STEPS].mode[0] != GM_MIX,
        dv_reg[DIV_STEPS][0].quo == 8'd0)

endmodule

`default_nettype wire
